[src/rbed_pkg.sv]
`default_nettype none
package rbed_pkg;
	localparam int SAMPLE_BITS = 16;
	localparam int SUM_W = 2 * SAMPLE_BITS + 1;
	localparam int MS_W = 2 * SAMPLE_BITS;
	localparam int RMS_W = SAMPLE_BITS + 1;
	localparam int X_W = RMS_W + 8;
	localparam int MEAN_W = 26;
	localparam int M2_W = 48;
	localparam int CNT_W = 14;
	localparam logic [M2_W-1:0] M2_MAX = {M2_W{1'b1}};

	localparam logic [2:0] REG_AMP = 3'd0;
	localparam logic [2:0] REG_DUR = 3'd1;
	localparam logic [2:0] REG_BASE = 3'd2;
	localparam logic [2:0] REG_REFR = 3'd3;
	localparam logic [2:0] REG_PULSE = 3'd4;

	typedef struct packed {
		logic load;
		logic sqrt_start;
		logic rms_load;
		logic sel_sd;
		logic sd_load;
		logic div_start;
		logic sel_m2;
		logic mean_upd;
		logic m2_upd;
		logic finish;
	} rbed_cmd_t;

	typedef struct packed {
		logic sqrt_busy;
		logic div_busy;
		logic base_due;
		logic base_nz;
	} rbed_sts_t;
endpackage
`default_nettype wire

[src/rms_burst_event_detector.sv]
// Each item runs in turn: a 32-step square root gives the RMS; while the baseline
// builds, a 64-step division updates the mean and M2; with a non-empty baseline, a
// further 64-step division and 32-step square root give the deviation. An item is
// taken once the last is done; results wait in the output register as the next is taken.
// Reset (arst_n low, asynchronous) clears statistics, counters and control registers
// and sets the configuration to its defaults; data registers are not reset.
`default_nettype none
module rms_burst_event_detector (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] sample_a,
	input  wire logic signed [15:0] sample_b,
	input  wire logic signed [15:0] sample_c,
	input  wire logic signed [15:0] sample_d,
	input  wire logic               block_start,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [15:0]             rms_value,
	output logic                    pulse_level,
	output logic                    pulse_rise,
	output logic                    pulse_fall,
	output logic                    baseline_done,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);
	import rbed_pkg::*;
	rbed_cmd_t cmd;
	rbed_sts_t sts;
	logic [11:0] amp_q, pulse_q;
	logic [12:0] dur_q;
	logic [13:0] base_q;
	logic [15:0] refr_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q <= 12'd512; dur_q <= 13'd20; base_q <= 14'd15000;
			refr_q <= 16'd15000; pulse_q <= 12'd1000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_AMP: amp_q <= cfg_data[11:0];
				REG_DUR: dur_q <= cfg_data[12:0];
				REG_BASE: base_q <= cfg_data[13:0];
				REG_REFR: refr_q <= cfg_data;
				REG_PULSE: pulse_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end
	rbed_ctrl u_ctrl (.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.sts, .cmd);
	rbed_datapath u_dp (.clk, .arst_n, .cmd, .sts, .sample_a, .sample_b, .sample_c,
		.sample_d, .block_start, .amp_k(amp_q), .dur_ms(dur_q), .base_pts(base_q),
		.refr_pts(refr_q), .pulse_pts(pulse_q), .rms_value, .pulse_level,
		.pulse_rise, .pulse_fall, .baseline_done);

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall) else $error("item taken while busy");
	a_rise_level: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pulse_rise) |-> pulse_level) else $error("rise without level");
	a_rise_fall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(pulse_rise && pulse_fall)) else $error("rise and fall");
endmodule
`default_nettype wire

[src/rbed_isqrt.sv]
`default_nettype none
module rbed_isqrt (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [63:0]           din,
	output logic                       busy,
	output logic [31:0]                root
);
	import rbed_pkg::*;
	logic [63:0] v_q;
	logic [63:0] r_q;
	logic [5:0]  n_q;
	logic [65:0] t;
	logic [63:0] bitv;
	always_comb begin
		bitv = 64'd1 << {n_q[4:0], 1'b0};
		t = {2'b0, v_q} - ({2'b0, r_q} + {2'b0, bitv});
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			n_q <= '0;
		end else if (start) begin
			busy <= 1'b1;
			n_q <= 6'd31;
		end else if (busy) begin
			if (n_q == 6'd0) busy <= 1'b0;
			n_q <= n_q - 6'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= din;
			r_q <= '0;
		end else if (busy) begin
			if (!t[65]) begin
				v_q <= t[63:0];
				r_q <= (r_q >> 1) + bitv;
			end else
				r_q <= r_q >> 1;
		end
	end
	assign root = r_q[31:0];
endmodule
`default_nettype wire

[src/rbed_div.sv]
`default_nettype none
module rbed_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] num,
	input  wire logic [15:0] den,
	output logic             busy,
	output logic [63:0]      quo
);
	import rbed_pkg::*;
	logic [63:0] q_q;
	logic [16:0] r_q;
	logic [15:0] d_q;
	logic [6:0]  n_q;
	logic [17:0] sh;
	logic [17:0] df;
	always_comb begin
		sh = {r_q, q_q[63]};
		df = sh - {2'b0, d_q};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			n_q <= '0;
		end else if (start) begin
			busy <= 1'b1;
			n_q <= 7'd63;
		end else if (busy) begin
			if (n_q == 7'd0) busy <= 1'b0;
			n_q <= n_q - 7'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy) begin
			if (!df[17]) begin
				r_q <= df[16:0];
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= sh[16:0];
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end
	assign quo = q_q;
endmodule
`default_nettype wire

[src/rbed_datapath.sv]
`default_nettype none
module rbed_datapath (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire rbed_pkg::rbed_cmd_t   cmd,
	output rbed_pkg::rbed_sts_t        sts,
	input  wire logic signed [15:0]    sample_a,
	input  wire logic signed [15:0]    sample_b,
	input  wire logic signed [15:0]    sample_c,
	input  wire logic signed [15:0]    sample_d,
	input  wire logic                  block_start,
	input  wire logic [11:0]           amp_k,
	input  wire logic [12:0]           dur_ms,
	input  wire logic [13:0]           base_pts,
	input  wire logic [15:0]           refr_pts,
	input  wire logic [11:0]           pulse_pts,
	output logic [15:0]                rms_value,
	output logic                       pulse_level,
	output logic                       pulse_rise,
	output logic                       pulse_fall,
	output logic                       baseline_done
);
	import rbed_pkg::*;
	logic [MS_W-1:0] ms_q;
	logic blk_q;
	logic [16:0] rms_q;
	logic [13:0] cnt_q;
	logic signed [MEAN_W-1:0] mean_q, delta_q, delta_v;
	logic [M2_W-1:0] m2_q;
	logic [15:0] run_q, since_q;
	logic ever_q, pact_q;
	logic [12:0] age_q;
	logic [31:0] sd_q;
	logic sq_busy, dv_busy;
	logic [31:0] root;
	logic [63:0] quo;
	logic [SUM_W:0] sum;
	logic [63:0] sq_in, dv_num;
	logic [15:0] dv_den;
	logic [24:0] x;
	logic [13:0] cnt_n;

	rbed_isqrt u_sqrt (.clk, .arst_n, .start(cmd.sqrt_start), .din(sq_in),
		.busy(sq_busy), .root);
	rbed_div u_div (.clk, .arst_n, .start(cmd.div_start), .num(dv_num),
		.den(dv_den), .busy(dv_busy), .quo);

	assign x = {rms_q[15:0] , 8'd0} | 25'd0;
	assign cnt_n = cnt_q + 14'd1;
	assign delta_v = $signed({1'b0, x}) - mean_q;

	always_comb begin
		sum = {1'b0, 33'(32'(sample_a * sample_a)) + 33'(32'(sample_b * sample_b))}
			+ {1'b0, 33'(32'(sample_c * sample_c)) + 33'(32'(sample_d * sample_d))};
		sq_in = cmd.sel_sd ? quo : {32'd0, ms_q};
		if (cmd.sel_m2) begin
			dv_num = {16'd0, m2_q};
			dv_den = {cnt_q, 2'b00};
		end else begin
			dv_num = {39'd0, delta_v[MEAN_W-1] ? 25'(-delta_v) : 25'(delta_v)};
			dv_den = {2'b00, cnt_n};
		end
	end

	logic signed [MEAN_W-1:0] mean_n, e_v;
	logic [25:0] a_v, b_v;
	logic [51:0] prod;
	logic [M2_W:0] m2_sum;
	logic [M2_W-1:0] m2_add;
	logic [36:0] thr;
	logic above, below, refr_ok, run_hit;
	logic [15:0] since_n, run_n;
	logic [15:0] need;
	always_comb begin
		mean_n = delta_q[MEAN_W-1] ? mean_q - MEAN_W'(quo) : mean_q + MEAN_W'(quo);
		e_v = $signed({1'b0, x}) - mean_n;
		a_v = delta_q[MEAN_W-1] ? 26'(-delta_q) : 26'(delta_q);
		b_v = e_v[MEAN_W-1] ? 26'(-e_v) : 26'(e_v);
		prod = 52'(a_v * b_v);
		if (delta_q[MEAN_W-1] != e_v[MEAN_W-1]) prod = '0;
		m2_add = (prod > 52'(M2_MAX)) ? M2_MAX : prod[M2_W-1:0];
		m2_sum = {1'b0, m2_q} + {1'b0, m2_add};
		since_n = (ever_q && since_q != 16'hFFFF) ? since_q + 16'd1 : since_q;
		refr_ok = !ever_q || since_n > refr_pts;
		thr = 37'(mean_q) + 37'((44'(amp_k) * 44'(sd_q)) >> 8);
		above = (cnt_q != 0) && ({12'd0, x} >= thr);
		below = (cnt_q != 0) && !above;
		run_n = run_q;
		if (above && refr_ok) begin
			if (run_q != 16'hFFFF) run_n = run_q + 16'd1;
		end else if (below && blk_q)
			run_n = '0;
		need = 16'((17'(dur_ms) * 17'd15 + 17'd1) >> 1);
		run_hit = run_n >= need && refr_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; mean_q <= '0; m2_q <= '0; run_q <= '0; since_q <= '0;
			ever_q <= 1'b0; pact_q <= 1'b0; age_q <= '0;
			pulse_level <= 1'b0; pulse_rise <= 1'b0; pulse_fall <= 1'b0;
			baseline_done <= 1'b0;
		end else begin
			if (cmd.mean_upd) begin
				cnt_q <= cnt_n;
				mean_q <= mean_n;
			end
			if (cmd.m2_upd) m2_q <= m2_sum[M2_W] ? M2_MAX : m2_sum[M2_W-1:0];
			if (cmd.finish) begin
				logic p, f;
				p = pact_q; f = 1'b0;
				since_q <= run_hit ? 16'd0 : since_n;
				run_q <= run_hit ? 16'd0 : run_n;
				if (run_hit) ever_q <= 1'b1;
				if (run_hit || p) begin
					if (!run_hit && age_q > {1'b0, pulse_pts}) begin
						p = 1'b0; f = 1'b1;
					end else begin
						p = 1'b1;
						age_q <= run_hit ? 13'd1 : age_q + 13'd1;
					end
				end
				pact_q <= p;
				pulse_level <= p;
				pulse_rise <= run_hit;
				pulse_fall <= f;
				baseline_done <= cnt_q >= base_pts;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ms_q <= MS_W'(sum >> 2);
			blk_q <= block_start;
		end
		if (cmd.rms_load) rms_q <= root[16:0];
		if (cmd.div_start && !cmd.sel_m2)
			delta_q <= delta_v;
		if (cmd.finish) rms_value <= rms_q[15:0];
		if (cmd.sd_load) sd_q <= root;
	end

	assign sts.sqrt_busy = sq_busy;
	assign sts.div_busy = dv_busy;
	assign sts.base_due = cnt_q < base_pts;
	assign sts.base_nz = cnt_q != 0;
endmodule
`default_nettype wire

[src/rbed_ctrl.sv]
`default_nettype none
module rbed_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	output logic                     out_valid,
	input  wire logic                out_stall,
	input  wire rbed_pkg::rbed_sts_t sts,
	output rbed_pkg::rbed_cmd_t      cmd
);
	import rbed_pkg::*;
	localparam logic [3:0] S_IDLE = 4'd0, S_RMS = 4'd1, S_RMSW = 4'd2,
		S_MDIV = 4'd3, S_MDIVW = 4'd4, S_MUPD = 4'd5, S_VDIV = 4'd6,
		S_VDIVW = 4'd7, S_SQ = 4'd8, S_SQW = 4'd9, S_FIN = 4'd10,
		S_RMS2 = 4'd11;
	logic [3:0] st_q, st_n;
	logic ov_n;
	always_comb begin
		cmd = '0;
		st_n = st_q;
		ov_n = out_valid && out_stall;
		in_stall = st_q != S_IDLE;
		unique case (st_q)
			S_IDLE: if (in_valid) begin
				cmd.load = 1'b1; st_n = S_RMS;
			end
			S_RMS: begin cmd.sqrt_start = 1'b1; st_n = S_RMSW; end
			S_RMSW: if (!sts.sqrt_busy) st_n = S_RMS2;
			S_RMS2: begin
				cmd.rms_load = 1'b1; st_n = S_MDIV;
			end
			S_MDIV: begin
				if (sts.base_due) begin
					cmd.div_start = 1'b1; st_n = S_MDIVW;
				end else st_n = S_VDIV;
			end
			S_MDIVW: if (!sts.div_busy) st_n = S_MUPD;
			S_MUPD: begin cmd.mean_upd = 1'b1; cmd.m2_upd = 1'b1; st_n = S_VDIV; end
			S_VDIV: begin
				if (sts.base_nz) begin
					cmd.sel_m2 = 1'b1; cmd.div_start = 1'b1; st_n = S_VDIVW;
				end else st_n = S_FIN;
			end
			S_VDIVW: if (!sts.div_busy) st_n = S_SQ;
			S_SQ: begin
				cmd.sel_sd = 1'b1; cmd.sqrt_start = 1'b1; st_n = S_SQW;
			end
			S_SQW: begin
				cmd.sel_sd = 1'b1;
				if (!sts.sqrt_busy) begin
					cmd.sd_load = 1'b1; st_n = S_FIN;
				end
			end
			S_FIN: if (!out_valid || !out_stall) begin
				cmd.finish = 1'b1; ov_n = 1'b1; st_n = S_IDLE;
			end
			default: st_n = S_IDLE;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; out_valid <= 1'b0;
		end else begin
			st_q <= st_n; out_valid <= ov_n;
		end
	end
endmodule
`default_nettype wire
